// ===== hdl/cgam_pkg.sv =====
// ----------------------------------------------------------------------------
// cgam_pkg: shared constants and types of the corner gradient alpha mask
// Widths, reset values and the divider stage record used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package cgam_pkg;

  localparam int MAX_RESOLUTION = 4096;
  localparam int MIN_RESOLUTION = 2;
  localparam int RES_RESET      = 64;

  localparam int RES_W     = 13;
  localparam int COORD_W   = $clog2(MAX_RESOLUTION);
  localparam int ALPHA_W   = 8;
  localparam int ALPHA_MAX = 255;
  localparam int CORNERS   = 4;

  // weight never exceeds R-1-R/4, so it fits the coordinate width
  localparam int WEIGHT_W   = COORD_W;
  localparam int TOTAL_W    = WEIGHT_W + 2;
  localparam int DIVIDEND_W = WEIGHT_W + ALPHA_W;
  localparam int DIV_CMP_W  = TOTAL_W + ALPHA_W - 1;
  localparam int DIV_STEPS  = ALPHA_W;

  localparam int ERR_W  = 2;
  localparam int RANK_W = 3;
  localparam int SUM_W  = ALPHA_W + 2;

  typedef struct packed {
    logic [CORNERS-1:0][DIVIDEND_W-1:0] rem;
    logic [CORNERS-1:0][ALPHA_W-1:0]    quo;
    logic [TOTAL_W-1:0]                 total;
    logic                               zero;
  } div_t;

endpackage

`default_nettype wire

// ===== hdl/corner_gradient_alpha_mask_core.sv =====
// ----------------------------------------------------------------------------
// corner_gradient_alpha_mask_core: four corner blend alphas per pixel
// Chebyshev corner weights, exact 255*w/total division, shortfall spread.
// ----------------------------------------------------------------------------
//  channel          handshake                  payload
//  pixel in         in_valid / in_stall        pixel_x, pixel_y
//  alphas out       out_valid / out_stall      alpha_top_left .. bottom_right
//  resolution cfg   cfg_valid / cfg_ready      tile_resolution
//
//  One pixel per cycle enters while the output is not stalled. The stages are clamp,
//  distance, weight, sum, eight restoring divider stages (one quotient bit each),
//  shortfall count and spread. The divider chain sets the depth.
//  Reset clears every valid bit and sets the resolution to 64.
//  A stalled output beat freezes the whole pipe and raises in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module corner_gradient_alpha_mask_core (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          cfg_valid,
  output logic                                cfg_ready,
  input  wire  logic [cgam_pkg::RES_W-1:0]    tile_resolution,
  input  wire  logic                          in_valid,
  output logic                                in_stall,
  input  wire  logic [cgam_pkg::COORD_W-1:0]  pixel_x,
  input  wire  logic [cgam_pkg::COORD_W-1:0]  pixel_y,
  output logic                                out_valid,
  input  wire  logic                          out_stall,
  output logic [cgam_pkg::ALPHA_W-1:0]        alpha_top_left,
  output logic [cgam_pkg::ALPHA_W-1:0]        alpha_bottom_left,
  output logic [cgam_pkg::ALPHA_W-1:0]        alpha_top_right,
  output logic [cgam_pkg::ALPHA_W-1:0]        alpha_bottom_right
);

  localparam int CW = cgam_pkg::COORD_W;
  localparam int WW = cgam_pkg::WEIGHT_W;
  localparam int NC = cgam_pkg::CORNERS;
  localparam int AW = cgam_pkg::ALPHA_W;
  localparam int DW = cgam_pkg::DIVIDEND_W;
  localparam int TW = cgam_pkg::TOTAL_W;
  localparam int XW = cgam_pkg::DIV_CMP_W;
  localparam int ND = cgam_pkg::DIV_STEPS;
  localparam int EW = cgam_pkg::ERR_W;
  localparam int RW = cgam_pkg::RANK_W;
  localparam int SW = cgam_pkg::SUM_W;

  // ---------------- configuration: keep R-1 and R-1-R/4 ready ----------------
  logic [CW-1:0]                 top;
  logic [CW-1:0]                 lim;
  logic [cgam_pkg::RES_W-1:0]    res_sat;
  logic [CW-1:0]                 top_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    res_sat = tile_resolution;
    if (tile_resolution < cgam_pkg::RES_W'(cgam_pkg::MIN_RESOLUTION))
      res_sat = cgam_pkg::RES_W'(cgam_pkg::MIN_RESOLUTION);
    if (tile_resolution > cgam_pkg::RES_W'(cgam_pkg::MAX_RESOLUTION))
      res_sat = cgam_pkg::RES_W'(cgam_pkg::MAX_RESOLUTION);
    top_next = CW'(res_sat - cgam_pkg::RES_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= CW'(cgam_pkg::RES_RESET - 1);
      lim <= CW'(cgam_pkg::RES_RESET - 1 - cgam_pkg::RES_RESET / 4);
    end else if (cfg_valid && cfg_ready) begin
      top <= top_next;
      lim <= top_next - CW'(res_sat >> 2);
    end
  end

  // ---------------- pipeline enable ----------------
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- stage 1: clamp coordinates ----------------
  logic          v1;
  logic [CW-1:0] x1, y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= (pixel_x > top) ? top : pixel_x;
      y1 <= (pixel_y > top) ? top : pixel_y;
    end
  end

  // ---------------- stage 2: Chebyshev distance to each corner ----------------
  logic                  v2;
  logic [NC-1:0][CW-1:0] d2;
  logic [NC-1:0][CW-1:0] d_next;
  logic [CW-1:0]         xf, yf;

  always_comb begin
    xf = top - x1;
    yf = top - y1;
    d_next[0] = (x1 > y1) ? x1 : y1;
    d_next[1] = (x1 > yf) ? x1 : yf;
    d_next[2] = (xf > y1) ? xf : y1;
    d_next[3] = (xf > yf) ? xf : yf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2 <= d_next;
    end
  end

  // ---------------- stage 3: corner weights ----------------
  logic                  v3;
  logic [NC-1:0][WW-1:0] w3;
  logic [NC-1:0][WW-1:0] w_next;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      w_next[i] = (d2[i] >= lim) ? '0 : WW'(lim - d2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w3 <= w_next;
    end
  end

  // ---------------- stage 4: total and 255*w, then divider chain ----------------
  logic [ND:0]      dvalid;
  cgam_pkg::div_t   dstage [0:ND];
  cgam_pkg::div_t   load_next;

  always_comb begin
    load_next.total = TW'(w3[0]) + TW'(w3[1]) + TW'(w3[2]) + TW'(w3[3]);
    load_next.zero  = (w3 == '0);
    load_next.quo   = '0;
    for (int i = 0; i < NC; i++) begin
      load_next.rem[i] = (DW'(w3[i]) << AW) - DW'(w3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid[0] <= 1'b0;
    end else if (en) begin
      dvalid[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dstage[0] <= load_next;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < ND; s++) begin : g_div
    localparam int Bit = ND - 1 - s;
    cgam_pkg::div_t step_next;
    logic [XW-1:0]  shifted;

    always_comb begin
      step_next = dstage[s];
      shifted   = XW'(dstage[s].total) << Bit;
      for (int i = 0; i < NC; i++) begin
        if (XW'(dstage[s].rem[i]) >= shifted) begin
          step_next.rem[i]      = DW'(XW'(dstage[s].rem[i]) - shifted);
          step_next.quo[i][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvalid[s+1] <= 1'b0;
      end else if (en) begin
        dvalid[s+1] <= dvalid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dstage[s+1] <= step_next;
      end
    end
  end

  // ---------------- stage 13: shortfall, nonzero count and ranks ----------------
  logic                  v13;
  logic [NC-1:0][AW-1:0] a13;
  logic [EW-1:0]         err13;
  logic [RW-1:0]         n13;
  logic [NC-1:0][RW-1:0] rank13;
  logic [NC-1:0][AW-1:0] a_next;
  logic [SW-1:0]         sum;
  logic [EW-1:0]         err_next;
  logic [RW-1:0]         n_next;
  logic [NC-1:0][RW-1:0] rank_next;

  always_comb begin
    sum    = '0;
    n_next = '0;
    for (int i = 0; i < NC; i++) begin
      a_next[i]    = dstage[ND].zero ? '0 : dstage[ND].quo[i];
      sum          = sum + SW'(a_next[i]);
      rank_next[i] = n_next;
      n_next       = n_next + RW'(a_next[i] != '0);
    end
    // each floor loses less than one, so the shortfall stays below four
    if (dstage[ND].zero || sum >= SW'(cgam_pkg::ALPHA_MAX))
      err_next = '0;
    else
      err_next = EW'(SW'(cgam_pkg::ALPHA_MAX) - sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v13 <= 1'b0;
    end else if (en) begin
      v13 <= dvalid[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a13    <= a_next;
      err13  <= err_next;
      n13    <= n_next;
      rank13 <= rank_next;
    end
  end

  // ---------------- stage 14: spread the shortfall, output register ----------------
  logic [NC-1:0][AW-1:0] out_next;
  logic [RW-1:0]         extra;
  logic [RW:0]           err_w;

  always_comb begin
    err_w = (RW+1)'(err13);
    for (int i = 0; i < NC; i++) begin
      // unit j goes to the corner whose rank is j mod n
      extra = '0;
      if ((RW+1)'(rank13[i]) < err_w)
        extra = extra + RW'(1);
      if ((RW+1)'(rank13[i]) + (RW+1)'(n13) < err_w)
        extra = extra + RW'(1);
      if ((RW+1)'(rank13[i]) + ((RW+1)'(n13) << 1) < err_w)
        extra = extra + RW'(1);
      if (a13[i] == '0)
        out_next[i] = '0;
      else
        out_next[i] = a13[i] + AW'(extra);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v13;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_top_left     <= out_next[0];
      alpha_bottom_left  <= out_next[1];
      alpha_top_right    <= out_next[2];
      alpha_bottom_right <= out_next[3];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cgam_checker.sv =====
// ----------------------------------------------------------------------------
// cgam_checker: port-level checks for the corner gradient alpha mask core
// Watches the handshakes and the alpha beats; bound to the core below.
// ----------------------------------------------------------------------------
`default_nettype none

module cgam_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [cgam_pkg::ALPHA_W-1:0] alpha_top_left,
  input wire logic [cgam_pkg::ALPHA_W-1:0] alpha_bottom_left,
  input wire logic [cgam_pkg::ALPHA_W-1:0] alpha_top_right,
  input wire logic [cgam_pkg::ALPHA_W-1:0] alpha_bottom_right
);

  localparam int SW = cgam_pkg::SUM_W;

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid right after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(alpha_top_left)
      && $stable(alpha_bottom_left) && $stable(alpha_top_right)
      && $stable(alpha_bottom_right)))
    else $error("stalled output beat changed");

  // the input side only backs up behind a blocked output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");

  // the four alphas always add up to full coverage
  a_alpha_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (SW'(alpha_top_left) + SW'(alpha_bottom_left)
      + SW'(alpha_top_right) + SW'(alpha_bottom_right)
      == SW'(cgam_pkg::ALPHA_MAX)))
    else $error("alphas do not sum to full scale");

endmodule

bind corner_gradient_alpha_mask_core cgam_checker u_cgam_checker (
  .clk                (clk),
  .rst                (rst),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .alpha_top_left     (alpha_top_left),
  .alpha_bottom_left  (alpha_bottom_left),
  .alpha_top_right    (alpha_top_right),
  .alpha_bottom_right (alpha_bottom_right)
);

`default_nettype wire
